@@ rtl/core/zsep_pkg.sv @@
// Shared types and constants for the ZIP stored-entry stream parser.
// No dependencies; used by every module of the block.
`default_nettype none

package zsep_pkg;

  // Record signatures and header checks
  localparam logic [31:0] SIG_LOCAL       = 32'h04034B50;
  localparam logic [31:0] SIG_CENTRAL     = 32'h02014B50;
  localparam logic [31:0] SIG_END         = 32'h06054B50;
  localparam logic [15:0] FLAG_DESCRIPTOR = 16'h0008;
  localparam logic [31:0] SIZE_ALL_ONES   = 32'hFFFFFFFF;
  localparam logic [4:0]  HDR_LAST_POS    = 5'd29;
  localparam logic [15:0] MAX_NAME_RESET  = 16'd259;

  // Parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_NAME   = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  // Byte classes
  localparam logic [2:0] CLS_HEADER = 3'd0;
  localparam logic [2:0] CLS_NAME   = 3'd1;
  localparam logic [2:0] CLS_EXTRA  = 3'd2;
  localparam logic [2:0] CLS_FILE   = 3'd3;
  localparam logic [2:0] CLS_DIR    = 3'd4;
  localparam logic [2:0] CLS_DONE   = 3'd5;
  localparam logic [2:0] CLS_ERROR  = 3'd6;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_DONE        = 3'd1;
  localparam logic [2:0] ST_BAD_SIG     = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_BAD_NAMELEN = 3'd4;
  localparam logic [2:0] ST_UNSAFE      = 3'd5;

  // Characters of interest in entry names
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Path check state carried across name bytes
  typedef struct packed {
    logic       zero_seen;
    logic       unsafe;
    logic [7:0] prev;
  } path_t;

  // One result item
  typedef struct packed {
    logic [2:0]  byte_class;
    logic [7:0]  byte_out;
    logic        entry_last;
    logic [2:0]  status;
    logic [31:0] entry_size;
    logic [15:0] name_length;
    logic        is_directory;
    logic [31:0] file_total;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/zip_stored_entry_stream_parser_unit.sv @@
// Top level of the ZIP stored-entry stream parser: handshakes, name length
// register and result register. Depends on zsep_pkg and zsep_core.
`default_nettype none

// Takes a ZIP archive one byte per item and returns one result item per
// byte, registered in the cycle after the byte is accepted. With out_ready held high a byte
// is taken every cycle; the figure is set by the single result register,
// which accepts a new item in the same cycle its held result is taken. Each
// result carries the byte, its class, the entry-complete flag and the latched
// status and entry fields as they stand after that byte. cfg_max_name_length
// may be written whenever the block is idle; in_ready and cfg_ready stay low
// while rst_n is low, and cfg_ready is high at all other times.
module zip_stored_entry_stream_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_byte_class,
  output logic [7:0]       out_byte_out,
  output logic             out_entry_last,
  output logic [2:0]       out_status,
  output logic [31:0]      out_entry_size,
  output logic [15:0]      out_name_length,
  output logic             out_is_directory,
  output logic [31:0]      out_file_total,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_max_name_length
);

  logic              out_valid_r;
  logic [15:0]       max_name_r;
  logic              accept;
  zsep_pkg::result_t res_nxt;
  zsep_pkg::result_t res_r;

  assign in_ready  = rst_n && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = rst_n;

  // Name length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_name_r <= zsep_pkg::MAX_NAME_RESET;
    end else if (cfg_valid) begin
      max_name_r <= cfg_max_name_length;
    end
  end

  zsep_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (accept),
    .data_byte    (in_data_byte),
    .max_name_len (max_name_r),
    .res_nxt      (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_class   = res_r.byte_class;
  assign out_byte_out     = res_r.byte_out;
  assign out_entry_last   = res_r.entry_last;
  assign out_status       = res_r.status;
  assign out_entry_size   = res_r.entry_size;
  assign out_name_length  = res_r.name_length;
  assign out_is_directory = res_r.is_directory;
  assign out_file_total   = res_r.file_total;

endmodule

`default_nettype wire

@@ rtl/core/zsep_path_check.sv @@
// Per-byte unsafe path check and trailing-slash tracking for entry names.
// Depends on zsep_pkg (path_t, character constants).
`default_nettype none

module zsep_path_check (
  input  wire logic [7:0]    data_byte,
  input  wire logic          first_pos,
  input  zsep_pkg::path_t    path_cur,
  output zsep_pkg::path_t    path_nxt
);

  always_comb begin
    path_nxt = path_cur;
    // Everything after the first zero byte is ignored
    if (!path_cur.zero_seen) begin
      if (data_byte == zsep_pkg::CH_NUL) begin
        path_nxt.zero_seen = 1'b1;
        if (first_pos) path_nxt.unsafe = 1'b1;
      end else begin
        if (data_byte == zsep_pkg::CH_COLON) path_nxt.unsafe = 1'b1;
        // leading slash or backslash
        if (first_pos && (data_byte == zsep_pkg::CH_SLASH ||
                          data_byte == zsep_pkg::CH_BSLASH)) begin
          path_nxt.unsafe = 1'b1;
        end
        // ".." anywhere
        if (!first_pos && data_byte == zsep_pkg::CH_DOT &&
            path_cur.prev == zsep_pkg::CH_DOT) begin
          path_nxt.unsafe = 1'b1;
        end
        path_nxt.prev = data_byte;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/zsep_core.sv @@
// Parser state and next-state logic: header gathering, checks, name/extra
// and data tracking. Depends on zsep_pkg and zsep_path_check.
`default_nettype none

module zsep_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    data_byte,
  input  wire logic [15:0]   max_name_len,
  output zsep_pkg::result_t  res_nxt
);

  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] sig_r, sig_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [15:0] method_r, method_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] name_len_r, name_len_nxt;
  logic [15:0] extra_len_r, extra_len_nxt;
  logic [16:0] ne_cnt_r, ne_cnt_nxt;
  logic [31:0] size_r, size_nxt;
  logic        dir_r, dir_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [31:0] files_r, files_nxt;
  zsep_pkg::path_t path_r, path_nxt, path_chk;

  logic [2:0]  cls;
  logic        last;
  logic [4:0]  size_off;
  logic [16:0] ne_total;
  logic [16:0] ne_cnt_inc;
  logic [31:0] bytes_dec;
  logic        name_byte;

  assign size_off   = hdr_cnt_r - 5'd18;
  assign ne_total   = {1'b0, name_len_r} + {1'b0, extra_len_r};
  assign ne_cnt_inc = ne_cnt_r + 17'd1;
  assign bytes_dec  = bytes_left_r - {31'd0, (bytes_left_r != 32'd0)};
  assign name_byte  = (ne_cnt_r < {1'b0, name_len_r});

  // Name byte check
  zsep_path_check u_path (
    .data_byte (data_byte),
    .first_pos (ne_cnt_r == 17'd0),
    .path_cur  (path_r),
    .path_nxt  (path_chk)
  );

  // Next state and result for the byte at the input
  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    sig_nxt        = sig_r;
    flags_nxt      = flags_r;
    method_nxt     = method_r;
    bytes_left_nxt = bytes_left_r;
    name_len_nxt   = name_len_r;
    extra_len_nxt  = extra_len_r;
    ne_cnt_nxt     = ne_cnt_r;
    size_nxt       = size_r;
    dir_nxt        = dir_r;
    status_nxt     = status_r;
    files_nxt      = files_r;
    path_nxt       = path_r;
    cls            = zsep_pkg::CLS_HEADER;
    last           = 1'b0;

    case (phase_r)
      zsep_pkg::PH_HEADER: begin
        cls = zsep_pkg::CLS_HEADER;
        // first header byte starts a fresh entry
        if (hdr_cnt_r == 5'd0) begin
          sig_nxt       = '0;
          flags_nxt     = '0;
          method_nxt    = '0;
          size_nxt      = '0;
          name_len_nxt  = '0;
          extra_len_nxt = '0;
          dir_nxt       = 1'b0;
        end
        // byte lanes of the little-endian header fields
        if (hdr_cnt_r < 5'd4) begin
          sig_nxt[{hdr_cnt_r[1:0], 3'b000} +: 8] = data_byte;
        end else if (hdr_cnt_r == 5'd6 || hdr_cnt_r == 5'd7) begin
          flags_nxt[{hdr_cnt_r[0], 3'b000} +: 8] = data_byte;
        end else if (hdr_cnt_r == 5'd8 || hdr_cnt_r == 5'd9) begin
          method_nxt[{hdr_cnt_r[0], 3'b000} +: 8] = data_byte;
        end else if (hdr_cnt_r >= 5'd18 && hdr_cnt_r < 5'd22) begin
          size_nxt[{size_off[1:0], 3'b000} +: 8] = data_byte;
        end else if (hdr_cnt_r == 5'd26 || hdr_cnt_r == 5'd27) begin
          name_len_nxt[{hdr_cnt_r[0], 3'b000} +: 8] = data_byte;
        end else if (hdr_cnt_r == 5'd28 || hdr_cnt_r == 5'd29) begin
          extra_len_nxt[{hdr_cnt_r[0], 3'b000} +: 8] = data_byte;
        end

        if (hdr_cnt_r == zsep_pkg::HDR_LAST_POS) begin
          hdr_cnt_nxt = 5'd0;
          // all checked fields are complete before the last header byte
          if (sig_r == zsep_pkg::SIG_CENTRAL || sig_r == zsep_pkg::SIG_END) begin
            phase_nxt  = zsep_pkg::PH_DONE;
            status_nxt = zsep_pkg::ST_DONE;
          end else if (sig_r != zsep_pkg::SIG_LOCAL) begin
            phase_nxt  = zsep_pkg::PH_ERROR;
            status_nxt = zsep_pkg::ST_BAD_SIG;
          end else if ((flags_r & zsep_pkg::FLAG_DESCRIPTOR) != 16'd0 ||
                       method_r != 16'd0 || size_r == zsep_pkg::SIZE_ALL_ONES) begin
            phase_nxt  = zsep_pkg::PH_ERROR;
            status_nxt = zsep_pkg::ST_UNSUPPORTED;
          end else if (name_len_r == 16'd0 || name_len_r > max_name_len) begin
            phase_nxt  = zsep_pkg::PH_ERROR;
            status_nxt = zsep_pkg::ST_BAD_NAMELEN;
          end else begin
            phase_nxt  = zsep_pkg::PH_NAME;
            ne_cnt_nxt = '0;
            path_nxt   = '0;
          end
        end else begin
          hdr_cnt_nxt = hdr_cnt_r + 5'd1;
        end
      end

      zsep_pkg::PH_NAME: begin
        if (name_byte) begin
          cls      = zsep_pkg::CLS_NAME;
          path_nxt = path_chk;
        end else begin
          cls = zsep_pkg::CLS_EXTRA;
        end
        ne_cnt_nxt = ne_cnt_inc;
        // end of name and extra field
        if (ne_cnt_inc >= ne_total) begin
          if (path_nxt.unsafe) begin
            phase_nxt  = zsep_pkg::PH_ERROR;
            status_nxt = zsep_pkg::ST_UNSAFE;
          end else begin
            dir_nxt = (path_nxt.prev == zsep_pkg::CH_SLASH ||
                       path_nxt.prev == zsep_pkg::CH_BSLASH);
            if (!dir_nxt) files_nxt = files_r + 32'd1;
            if (size_r == 32'd0) begin
              last      = 1'b1;
              phase_nxt = zsep_pkg::PH_HEADER;
            end else begin
              bytes_left_nxt = size_r;
              phase_nxt      = zsep_pkg::PH_DATA;
            end
          end
        end
      end

      zsep_pkg::PH_DATA: begin
        cls            = dir_r ? zsep_pkg::CLS_DIR : zsep_pkg::CLS_FILE;
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == 32'd0) begin
          last      = 1'b1;
          phase_nxt = zsep_pkg::PH_HEADER;
        end
      end

      zsep_pkg::PH_DONE: begin
        cls = zsep_pkg::CLS_DONE;
      end

      default: begin
        cls = zsep_pkg::CLS_ERROR;
      end
    endcase
  end

  // Result as seen after this byte
  always_comb begin
    res_nxt.byte_class   = cls;
    res_nxt.byte_out     = data_byte;
    res_nxt.entry_last   = last;
    res_nxt.status       = status_nxt;
    res_nxt.entry_size   = size_nxt;
    res_nxt.name_length  = name_len_nxt;
    res_nxt.is_directory = dir_nxt;
    res_nxt.file_total   = files_nxt;
  end

  // State registers advance once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= zsep_pkg::PH_HEADER;
      hdr_cnt_r    <= '0;
      sig_r        <= '0;
      flags_r      <= '0;
      method_r     <= '0;
      bytes_left_r <= '0;
      name_len_r   <= '0;
      extra_len_r  <= '0;
      ne_cnt_r     <= '0;
      size_r       <= '0;
      dir_r        <= 1'b0;
      status_r     <= zsep_pkg::ST_OK;
      files_r      <= '0;
      path_r       <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      sig_r        <= sig_nxt;
      flags_r      <= flags_nxt;
      method_r     <= method_nxt;
      bytes_left_r <= bytes_left_nxt;
      name_len_r   <= name_len_nxt;
      extra_len_r  <= extra_len_nxt;
      ne_cnt_r     <= ne_cnt_nxt;
      size_r       <= size_nxt;
      dir_r        <= dir_nxt;
      status_r     <= status_nxt;
      files_r      <= files_nxt;
      path_r       <= path_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/zsep_checker.sv @@
// Port-level checks for the ZIP stored-entry stream parser, bound to the top.
// Depends on zsep_pkg and zip_stored_entry_stream_parser_unit.
`default_nettype none

module zsep_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_byte_class,
  input wire logic [7:0]  out_byte_out,
  input wire logic        out_entry_last,
  input wire logic [2:0]  out_status,
  input wire logic        out_is_directory,
  input wire logic [31:0] out_file_total
);

  logic [2:0] last_status_r;
  logic       out_take;

  assign out_take = out_valid && out_ready;

  // status of the most recently delivered item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_status_r <= zsep_pkg::ST_OK;
    end else if (out_take) begin
      last_status_r <= out_status;
    end
  end

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_out) &&
      $stable(out_byte_class) && $stable(out_status) && $stable(out_file_total))
    else $error("result changed while stalled");

  // done or error status never changes once reported
  a_status_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_status_r != zsep_pkg::ST_OK |-> out_status == last_status_r)
    else $error("latched status changed");

  // class after done or error agrees with the status
  a_class_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_class == zsep_pkg::CLS_DONE ||
                  out_byte_class == zsep_pkg::CLS_ERROR) |->
      (out_byte_class == zsep_pkg::CLS_DONE) == (out_status == zsep_pkg::ST_DONE) &&
      out_status != zsep_pkg::ST_OK)
    else $error("class and status disagree");

  // entry completion only on name, extra or data bytes
  a_last_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_last |->
      out_byte_class == zsep_pkg::CLS_NAME || out_byte_class == zsep_pkg::CLS_EXTRA ||
      out_byte_class == zsep_pkg::CLS_FILE || out_byte_class == zsep_pkg::CLS_DIR)
    else $error("entry_last on a wrong byte class");

  // directory data only for directory entries
  a_dir_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_class == zsep_pkg::CLS_DIR |-> out_is_directory)
    else $error("directory data on a file entry");

endmodule

bind zip_stored_entry_stream_parser_unit zsep_checker u_zsep_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_byte_class   (out_byte_class),
  .out_byte_out     (out_byte_out),
  .out_entry_last   (out_entry_last),
  .out_status       (out_status),
  .out_is_directory (out_is_directory),
  .out_file_total   (out_file_total)
);

`default_nettype wire
